// File: rtl/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ezr_pkg.sv
// ----------------------------------------------------------------------------
// ezr_pkg
// Types, constants and arithmetic helpers for the euler-to-rotation pipeline.
// ----------------------------------------------------------------------------
package ezr_pkg;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] QONE        = 31'h4000_0000;
  localparam int          TAYLOR_TERMS = 8;

  // per-angle taylor state traveling down the series pipeline
  typedef struct packed {
    logic [31:0]        x2;
    logic [30:0]        ts;
    logic [30:0]        tc;
    logic signed [33:0] ss;
    logic signed [33:0] cs;
    logic [1:0]         quad;
  } ezr_sc_t;

  // sign and magnitude of a q30 by q30 product
  typedef struct packed {
    logic        neg;
    logic [60:0] mag;
  } ezr_prod_t;

  // pipeline control
  typedef struct packed {
    logic en;
    logic valid;
  } ezr_ctl_t;

  function automatic ezr_prod_t mul_f(input logic signed [31:0] a,
                                      input logic signed [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    ezr_prod_t   p;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    p.neg = a[31] ^ b[31];
    p.mag = 61'(ma[30:0]) * 61'(mb[30:0]);
    return p;
  endfunction

  function automatic logic signed [31:0] rnd_f(input ezr_prod_t p);
    logic [60:0] t;
    logic [31:0] m;
    t = p.mag + 61'(32'h2000_0000);
    m = {1'b0, t[60:30]};
    return p.neg ? 32'(-$signed(m)) : $signed(m);
  endfunction

endpackage

// File: rtl/ezr_if.sv
// ----------------------------------------------------------------------------
// ezr interfaces
// Valid/ready channels for angles, matrix results and configuration.
// ----------------------------------------------------------------------------
interface ezr_angle_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] roll_angle;
  logic signed [W-1:0] pitch_angle;
  logic signed [W-1:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface ezr_matrix_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] m00;
  logic signed [W-1:0] m01;
  logic signed [W-1:0] m02;
  logic signed [W-1:0] m10;
  logic signed [W-1:0] m11;
  logic signed [W-1:0] m12;
  logic signed [W-1:0] m20;
  logic signed [W-1:0] m21;
  logic signed [W-1:0] m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface ezr_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] zero_threshold;
  modport source (output valid, zero_threshold, input ready);
  modport sink   (input valid, zero_threshold, output ready);
endinterface

// File: rtl/ezr_term.sv
// ----------------------------------------------------------------------------
// ezr_term
// One taylor term for sine and cosine: multiply, divide by constant, add or subtract.
// ----------------------------------------------------------------------------
module ezr_term #(
  parameter int K = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ezr_pkg::ezr_ctl_t ctl_i,
  input  ezr_pkg::ezr_sc_t sc_i,
  output logic             valid_o,
  output ezr_pkg::ezr_sc_t sc_o
);

  localparam int          DS = (2 * K) * (2 * K + 1);
  localparam int          DC = (2 * K - 1) * (2 * K);
  localparam logic [31:0] MS = 32'(64'h1_0000_0000 / DS);
  localparam logic [31:0] MC = 32'(64'h1_0000_0000 / DC);

  ezr_pkg::ezr_sc_t s1_q, s2_q, s3_q;
  logic [62:0]      ps1_q, pc1_q;
  logic [31:0]      ns2_q, nc2_q;
  logic [63:0]      ms2_q, mc2_q;
  logic             v1_q, v2_q, v3_q;

  logic [31:0] ns_d, nc_d;
  logic [31:0] qs0, qc0, rs, rc, qs, qc;
  ezr_pkg::ezr_sc_t s3_d;

  always_comb begin
    ns_d = ps1_q[61:30];
    nc_d = pc1_q[61:30];
    qs0  = ms2_q[63:32];
    qc0  = mc2_q[63:32];
    rs   = ns2_q - 32'(qs0 * 32'(DS));
    rc   = nc2_q - 32'(qc0 * 32'(DC));
    qs   = (rs >= 32'(DS)) ? qs0 + 32'd1 : qs0;
    qc   = (rc >= 32'(DC)) ? qc0 + 32'd1 : qc0;
    s3_d    = s2_q;
    s3_d.ts = qs[30:0];
    s3_d.tc = qc[30:0];
    if (K % 2 == 1) begin
      s3_d.ss = s2_q.ss - $signed({3'b000, qs[30:0]});
      s3_d.cs = s2_q.cs - $signed({3'b000, qc[30:0]});
    end else begin
      s3_d.ss = s2_q.ss + $signed({3'b000, qs[30:0]});
      s3_d.cs = s2_q.cs + $signed({3'b000, qc[30:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      s1_q  <= sc_i;
      ps1_q <= 63'(sc_i.ts) * 63'(sc_i.x2);
      pc1_q <= 63'(sc_i.tc) * 63'(sc_i.x2);
      s2_q  <= s1_q;
      ns2_q <= ns_d;
      nc2_q <= nc_d;
      ms2_q <= 64'(ns_d) * 64'(MS);
      mc2_q <= 64'(nc_d) * 64'(MC);
      s3_q  <= s3_d;
    end
  end

  assign valid_o = v3_q;
  assign sc_o    = s3_q;

endmodule

// File: rtl/ezr_sincos.sv
// ----------------------------------------------------------------------------
// ezr_sincos
// Quadrant reduction, taylor series pipeline and quadrant mapping.
// ----------------------------------------------------------------------------
module ezr_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ezr_pkg::ezr_ctl_t      ctl_i,
  input  logic [ANGLE_BITS-1:0]  angle_i,
  output logic                   valid_o,
  output logic signed [31:0]     sin_o,
  output logic signed [31:0]     cos_o
);

  localparam int N = ezr_pkg::TAYLOR_TERMS;

  logic [31:0] turn;
  logic [1:0]  quad1_q, quad2_q;
  logic [60:0] pr1_q;
  logic [30:0] x2_q;
  logic [61:0] px2_q;
  logic        v1_q, v2_q, vo_q;
  logic [30:0] x_d;

  ezr_pkg::ezr_sc_t  stg [N+1];
  logic              vld [N+1];
  ezr_pkg::ezr_ctl_t tctl [N];

  logic [30:0] sm, cm;
  logic signed [31:0] sin_d, cos_d;
  logic signed [31:0] sin_q, cos_q;

  assign turn = 32'(angle_i) << (32 - ANGLE_BITS);
  assign x_d  = pr1_q[60:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      vo_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      quad1_q <= turn[31:30];
      pr1_q   <= 61'(turn[29:0]) * 61'(ezr_pkg::HALF_PI_Q30);
      quad2_q <= quad1_q;
      x2_q    <= x_d;
      px2_q   <= 62'(x_d) * 62'(x_d);
      sin_q   <= sin_d;
      cos_q   <= cos_d;
    end
  end

  assign stg[0].x2   = px2_q[61:30];
  assign stg[0].ts   = x2_q;
  assign stg[0].tc   = ezr_pkg::QONE;
  assign stg[0].ss   = $signed({3'b000, x2_q});
  assign stg[0].cs   = $signed({3'b000, ezr_pkg::QONE});
  assign stg[0].quad = quad2_q;
  assign vld[0]      = v2_q;

  for (genvar k = 0; k < N; k++) begin : g_term
    assign tctl[k].en    = ctl_i.en;
    assign tctl[k].valid = vld[k];
    ezr_term #(.K(k + 1)) u_term (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (tctl[k]),
      .sc_i    (stg[k]),
      .valid_o (vld[k+1]),
      .sc_o    (stg[k+1])
    );
  end

  always_comb begin
    if (stg[N].ss < 0) begin
      sm = '0;
    end else if (stg[N].ss > $signed({3'b000, ezr_pkg::QONE})) begin
      sm = ezr_pkg::QONE;
    end else begin
      sm = stg[N].ss[30:0];
    end
    if (stg[N].cs < 0) begin
      cm = '0;
    end else if (stg[N].cs > $signed({3'b000, ezr_pkg::QONE})) begin
      cm = ezr_pkg::QONE;
    end else begin
      cm = stg[N].cs[30:0];
    end
    unique case (stg[N].quad)
      2'd0: begin
        sin_d = $signed({1'b0, sm});
        cos_d = $signed({1'b0, cm});
      end
      2'd1: begin
        sin_d = $signed({1'b0, cm});
        cos_d = -$signed({1'b0, sm});
      end
      2'd2: begin
        sin_d = -$signed({1'b0, sm});
        cos_d = -$signed({1'b0, cm});
      end
      default: begin
        sin_d = -$signed({1'b0, cm});
        cos_d = $signed({1'b0, sm});
      end
    endcase
  end

  assign valid_o = vo_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

// File: rtl/ezr_matrix.sv
// ----------------------------------------------------------------------------
// ezr_matrix
// Products, sums, output rounding, saturation and zero threshold.
// ----------------------------------------------------------------------------
module ezr_matrix #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ezr_pkg::ezr_ctl_t     ctl_i,
  input  logic signed [31:0]    sa_i,
  input  logic signed [31:0]    ca_i,
  input  logic signed [31:0]    sb_i,
  input  logic signed [31:0]    cb_i,
  input  logic signed [31:0]    sg_i,
  input  logic signed [31:0]    cg_i,
  input  logic [14:0]           thr_i,
  output logic                  valid_o,
  output logic [8:0][OUT_FRAC_BITS+1:0] m_o
);

  localparam int          OW   = OUT_FRAC_BITS + 2;
  localparam int          SH   = 30 - OUT_FRAC_BITS;
  localparam logic [33:0] HALF = (SH > 0) ? (34'd1 << ((SH > 0) ? SH - 1 : 0)) : 34'd0;
  localparam logic [33:0] ONE  = 34'd1 << OUT_FRAC_BITS;

  // stage 1: pair products
  ezr_pkg::ezr_prod_t p1_q [10];
  logic signed [31:0] sa1_q, ca1_q, sb1_q;
  // stage 2: rounded pairs
  logic signed [31:0] r2_q [10];
  logic signed [31:0] sa2_q, ca2_q, sb2_q;
  // stage 3: triple products
  ezr_pkg::ezr_prod_t t3_q [4];
  logic signed [31:0] r3_q [10];
  logic signed [31:0] sb3_q;
  // stage 4: rounded triples
  logic signed [31:0] t4_q [4];
  logic signed [31:0] r4_q [10];
  logic signed [31:0] sb4_q;
  // stage 5: rounded magnitudes
  logic               neg5_q [9];
  logic [33:0]        mag5_q [9];
  // stage 6: output
  logic [8:0][OW-1:0] m6_q;

  logic [5:0]         v_q;
  logic signed [32:0] sum_d [9];
  logic               neg_d [9];
  logic [33:0]        mag_d [9];
  logic [33:0]        sat_d [9];
  logic [8:0][OW-1:0] m6_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[4:0], ctl_i.valid};
    end
  end

  // index: 0 cg*sb, 1 sg*sb, 2 cg*cb, 3 sg*ca, 4 sg*sa, 5 sg*cb,
  //        6 cg*ca, 7 cg*sa, 8 cb*sa, 9 cb*ca
  always_comb begin
    sum_d[0] = 33'(r4_q[2]);
    sum_d[1] = 33'(t4_q[0]) - 33'(r4_q[3]);
    sum_d[2] = 33'(t4_q[1]) + 33'(r4_q[4]);
    sum_d[3] = 33'(r4_q[5]);
    sum_d[4] = 33'(t4_q[2]) + 33'(r4_q[6]);
    sum_d[5] = 33'(t4_q[3]) - 33'(r4_q[7]);
    sum_d[6] = -33'(sb4_q);
    sum_d[7] = 33'(r4_q[8]);
    sum_d[8] = 33'(r4_q[9]);
    for (int i = 0; i < 9; i++) begin
      neg_d[i] = sum_d[i][32];
      mag_d[i] = (34'(neg_d[i] ? 33'(-sum_d[i]) : 33'(sum_d[i])) + HALF) >> SH;
      sat_d[i] = (mag5_q[i] > ONE) ? ONE : mag5_q[i];
      if (sat_d[i] < 34'(thr_i)) begin
        sat_d[i] = '0;
      end
      m6_d[i] = neg5_q[i] ? OW'(-sat_d[i]) : OW'(sat_d[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      p1_q[0] <= ezr_pkg::mul_f(cg_i, sb_i);
      p1_q[1] <= ezr_pkg::mul_f(sg_i, sb_i);
      p1_q[2] <= ezr_pkg::mul_f(cg_i, cb_i);
      p1_q[3] <= ezr_pkg::mul_f(sg_i, ca_i);
      p1_q[4] <= ezr_pkg::mul_f(sg_i, sa_i);
      p1_q[5] <= ezr_pkg::mul_f(sg_i, cb_i);
      p1_q[6] <= ezr_pkg::mul_f(cg_i, ca_i);
      p1_q[7] <= ezr_pkg::mul_f(cg_i, sa_i);
      p1_q[8] <= ezr_pkg::mul_f(cb_i, sa_i);
      p1_q[9] <= ezr_pkg::mul_f(cb_i, ca_i);
      sa1_q   <= sa_i;
      ca1_q   <= ca_i;
      sb1_q   <= sb_i;
      for (int i = 0; i < 10; i++) begin
        r2_q[i] <= ezr_pkg::rnd_f(p1_q[i]);
        r3_q[i] <= r2_q[i];
        r4_q[i] <= r3_q[i];
      end
      sa2_q   <= sa1_q;
      ca2_q   <= ca1_q;
      sb2_q   <= sb1_q;
      t3_q[0] <= ezr_pkg::mul_f(r2_q[0], sa2_q);
      t3_q[1] <= ezr_pkg::mul_f(r2_q[0], ca2_q);
      t3_q[2] <= ezr_pkg::mul_f(r2_q[1], sa2_q);
      t3_q[3] <= ezr_pkg::mul_f(r2_q[1], ca2_q);
      sb3_q   <= sb2_q;
      for (int i = 0; i < 4; i++) begin
        t4_q[i] <= ezr_pkg::rnd_f(t3_q[i]);
      end
      sb4_q   <= sb3_q;
      for (int i = 0; i < 9; i++) begin
        neg5_q[i] <= neg_d[i];
        mag5_q[i] <= mag_d[i];
      end
      m6_q    <= m6_d;
    end
  end

  assign valid_o = v_q[5];
  assign m_o     = m6_q;

endmodule

// File: rtl/euler_zyx_to_rotation_matrix_top.sv
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix_top
// ZYX euler angles to a 3x3 rotation matrix in signed fixed point.
// ----------------------------------------------------------------------------
// takes one angle transaction per cycle and returns one matrix transaction per
// angle transaction, after quadrant reduction, a taylor series over 8 terms,
// quadrant mapping and the matrix products and output rounding; a held result
// stalls the whole pipeline
module euler_zyx_to_rotation_matrix_top #(
  parameter int ANGLE_BITS    = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ezr_cfg_if.sink        cfg_i,
  ezr_angle_if.sink      angle_i,
  ezr_matrix_if.source   matrix_o
);

  localparam int OW = OUT_FRAC_BITS + 2;

  logic [14:0]        thr_q;
  ezr_pkg::ezr_ctl_t  ctl;
  logic               va, vb, vg, vm;
  logic signed [31:0] sa, ca, sb, cb, sg, cg;
  ezr_pkg::ezr_ctl_t  mctl;
  logic [8:0][OW-1:0] m;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 15'd164;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.zero_threshold;
    end
  end

  assign ctl.en        = !vm || matrix_o.ready;
  assign ctl.valid     = angle_i.valid;
  assign angle_i.ready = ctl.en;

  ezr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (ctl),
    .angle_i (ANGLE_BITS'(angle_i.roll_angle)),
    .valid_o (va), .sin_o (sa), .cos_o (ca)
  );

  ezr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (ctl),
    .angle_i (ANGLE_BITS'(angle_i.pitch_angle)),
    .valid_o (vb), .sin_o (sb), .cos_o (cb)
  );

  ezr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (ctl),
    .angle_i (ANGLE_BITS'(angle_i.yaw_angle)),
    .valid_o (vg), .sin_o (sg), .cos_o (cg)
  );

  assign mctl.en    = ctl.en;
  assign mctl.valid = va && vb && vg;

  ezr_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (mctl),
    .sa_i (sa), .ca_i (ca), .sb_i (sb), .cb_i (cb), .sg_i (sg), .cg_i (cg),
    .thr_i (thr_q), .valid_o (vm), .m_o (m)
  );

  assign matrix_o.valid = vm;
  assign matrix_o.m00   = m[0];
  assign matrix_o.m01   = m[1];
  assign matrix_o.m02   = m[2];
  assign matrix_o.m10   = m[3];
  assign matrix_o.m11   = m[4];
  assign matrix_o.m12   = m[5];
  assign matrix_o.m20   = m[6];
  assign matrix_o.m21   = m[7];
  assign matrix_o.m22   = m[8];

endmodule

// File: rtl/ezr_checker.sv
// ----------------------------------------------------------------------------
// ezr_checker
// Port-level checks on the euler-to-rotation block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ezr_checker #(
  parameter int OW = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic signed [OW-1:0] m00_i,
  input logic signed [OW-1:0] m20_i
);

  localparam logic signed [OW-1:0] ONE = OW'(1) <<< (OW - 2);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(m00_i) && $stable(m20_i), "result changed while stalled")
  `ASSERT_ALWAYS(a_ready_free, clk_i, !out_valid_i |-> in_ready_i, "input stalled with no result pending")
  `ASSERT_CLK(a_range, clk_i, rst_ni, out_valid_i |-> m00_i <= ONE && m00_i >= -ONE && m20_i <= ONE && m20_i >= -ONE, "matrix entry beyond unit range")

endmodule

bind euler_zyx_to_rotation_matrix_top ezr_checker #(.OW(OUT_FRAC_BITS + 2)) u_ezr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (angle_i.valid),
  .in_ready_i  (angle_i.ready),
  .out_valid_i (matrix_o.valid),
  .out_ready_i (matrix_o.ready),
  .m00_i       (matrix_o.m00),
  .m20_i       (matrix_o.m20)
);

// File: tb/sv/euler_zyx_to_rotation_matrix_top_test.sv
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix_top_test
// Drives angle transactions into the rotation matrix pipeline under random
// idling on both channels and checks every matrix transaction against a
// bit-exact predictor of the taylor series sine/cosine and product rounding.
// ----------------------------------------------------------------------------
module euler_zyx_to_rotation_matrix_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] m [9];
  } rot_mat_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic [14:0]        thr;
    bit                 has_fixed;
    logic signed [15:0] fixed [9];
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ezr_cfg_if    cfg_if ();
  ezr_angle_if  ang_if ();
  ezr_matrix_if mat_if ();

  euler_zyx_to_rotation_matrix_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if.sink),
    .angle_i (ang_if.sink),
    .matrix_o(mat_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  rot_mat_t   pending_mats [$];
  logic [14:0] cur_thr;
  int         n_err;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         quiet_cycles;

  function automatic void sin_cos_q30(input logic [15:0] raw,
                                      output longint s, output longint c);
    bit [31:0]   turn;
    bit [1:0]    quad;
    bit [63:0]   r, x, x2, ts, tc, ds, dc;
    longint      ss, cs;
    turn = {raw, 16'h0};
    quad = turn[31:30];
    r = {34'h0, turn[29:0]};
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = longint'(x);
    cs = longint'(64'd1 << 30);
    for (int k = 1; k <= 8; k++) begin
      ds = 64'(2 * k) * 64'(2 * k + 1);
      dc = 64'(2 * k - 1) * 64'(2 * k);
      ts = ((ts * x2) >> 30) / ds;
      tc = ((tc * x2) >> 30) / dc;
      if (k % 2 == 1) begin
        ss -= longint'(ts);
        cs -= longint'(tc);
      end else begin
        ss += longint'(ts);
        cs += longint'(tc);
      end
    end
    if (ss < 0) ss = 0;
    if (ss > (64'sd1 << 30)) ss = 64'sd1 << 30;
    if (cs < 0) cs = 0;
    if (cs > (64'sd1 << 30)) cs = 64'sd1 << 30;
    case (quad)
      2'd0: begin s = ss;  c = cs;  end
      2'd1: begin s = cs;  c = -ss; end
      2'd2: begin s = -ss; c = -cs; end
      default: begin s = -cs; c = ss; end
    endcase
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    bit        neg;
    bit [63:0] ma, mb, p;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb + (64'd1 << 29)) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [15:0] to_q14(input longint v, input logic [14:0] thr);
    bit        neg;
    bit [63:0] m;
    longint    q;
    neg = v < 0;
    m = neg ? -v : v;
    m = (m + (64'd1 << 15)) >> 16;
    if (m > 64'd16384) m = 64'd16384;
    if (m < 64'(thr)) m = 0;
    q = neg ? -longint'(m) : longint'(m);
    return q[15:0];
  endfunction

  function automatic rot_mat_t predict_rotation(input logic [15:0] roll, input logic [15:0] pitch,
                                                input logic [15:0] yaw, input logic [14:0] thr);
    longint   sa, ca, sb, cb, sg, cg, cgsb, sgsb;
    rot_mat_t r;
    sin_cos_q30(roll, sa, ca);
    sin_cos_q30(pitch, sb, cb);
    sin_cos_q30(yaw, sg, cg);
    cgsb = mul_q30(cg, sb);
    sgsb = mul_q30(sg, sb);
    r.m[0] = to_q14(mul_q30(cg, cb), thr);
    r.m[1] = to_q14(mul_q30(cgsb, sa) - mul_q30(sg, ca), thr);
    r.m[2] = to_q14(mul_q30(cgsb, ca) + mul_q30(sg, sa), thr);
    r.m[3] = to_q14(mul_q30(sg, cb), thr);
    r.m[4] = to_q14(mul_q30(sgsb, sa) + mul_q30(cg, ca), thr);
    r.m[5] = to_q14(mul_q30(sgsb, ca) - mul_q30(cg, sa), thr);
    r.m[6] = to_q14(-sb, thr);
    r.m[7] = to_q14(mul_q30(cb, sa), thr);
    r.m[8] = to_q14(mul_q30(cb, ca), thr);
    return r;
  endfunction

  // result side: random stall and compare
  always @(posedge clk_i) begin
    rot_mat_t           want;
    logic signed [15:0] got [9];
    string              names [9];
    names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
    if (rst_ni) begin
      if (mat_if.valid && mat_if.ready) begin
        got = '{mat_if.m00, mat_if.m01, mat_if.m02, mat_if.m10, mat_if.m11,
                mat_if.m12, mat_if.m20, mat_if.m21, mat_if.m22};
        if (pending_mats.size() == 0) begin
          $error("matrix transaction with nothing pending");
          n_err++;
        end else begin
          want = pending_mats.pop_front();
          for (int i = 0; i < 9; i++)
            if (got[i] !== want.m[i]) begin
              $error("%s expected %0d actual %0d", names[i], want.m[i], got[i]);
              n_err++;
            end
        end
      end
      mat_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on accepted transactions
  always @(posedge clk_i) begin
    if ((ang_if.valid && ang_if.ready) || (mat_if.valid && mat_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("euler_zyx_to_rotation_matrix_top_test: errors");
      $finish;
    end
  end

  task automatic write_threshold(input logic [14:0] thr);
    cfg_if.valid <= 1'b1;
    cfg_if.zero_threshold <= thr;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_thr = thr;
  endtask

  task automatic drain_results();
    while (pending_mats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_angles(input logic [15:0] roll, input logic [15:0] pitch,
                             input logic [15:0] yaw);
    while ($urandom_range(99) < send_idle_pct) begin
      ang_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    ang_if.valid <= 1'b1;
    ang_if.roll_angle <= roll;
    ang_if.pitch_angle <= pitch;
    ang_if.yaw_angle <= yaw;
    pending_mats.push_back(predict_rotation(roll, pitch, yaw, cur_thr));
    do @(posedge clk_i); while (!ang_if.ready);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(3)) << 14;
      default: return 16'($urandom);
    endcase
  endfunction

  stim_row_t table_rows [$];

  task automatic add_row(input logic [15:0] r, input logic [15:0] p, input logic [15:0] y,
                         input logic [14:0] thr, input bit fx,
                         input logic signed [15:0] m0, input logic signed [15:0] m4,
                         input logic signed [15:0] m8);
    stim_row_t row;
    row.roll = r;
    row.pitch = p;
    row.yaw = y;
    row.thr = thr;
    row.has_fixed = fx;
    row.fixed = '{m0, 0, 0, 0, m4, 0, 0, 0, m8};
    table_rows.push_back(row);
  endtask

  initial begin
    rot_mat_t pm;
    n_err = 0;
    quiet_cycles = 0;
    cur_thr = 15'd164;
    send_idle_pct = 14;
    recv_idle_pct = 76;
    cfg_if.valid = 1'b0;
    cfg_if.zero_threshold = '0;
    ang_if.valid = 1'b0;
    ang_if.roll_angle = '0;
    ang_if.pitch_angle = '0;
    ang_if.yaw_angle = '0;
    mat_if.ready = 1'b0;

    // zero angles give identity; threshold above one zeroes all
    add_row(16'h0000, 16'h0000, 16'h0000, 15'd164, 1'b1, 16384, 16384, 16384);
    add_row(16'h0000, 16'h0000, 16'h0000, 15'd16384, 1'b0, 0, 0, 0);
    add_row(16'h1234, 16'h4321, 16'h0f0f, 15'd16385, 1'b1, 0, 0, 0);
    add_row(16'h1234, 16'h4321, 16'h0f0f, 15'h7fff, 1'b1, 0, 0, 0);
    add_row(16'h8000, 16'h8000, 16'h8000, 15'd0, 1'b0, 0, 0, 0);
    add_row(16'h7fff, 16'h7fff, 16'h7fff, 15'd0, 1'b0, 0, 0, 0);
    add_row(16'h4000, 16'hc000, 16'h4000, 15'd0, 1'b0, 0, 0, 0);
    add_row(16'h4000, 16'h4000, 16'hc000, 15'd164, 1'b0, 0, 0, 0);
    add_row(16'h0001, 16'hffff, 16'h0001, 15'd0, 1'b0, 0, 0, 0);
    add_row(16'h2000, 16'h2000, 16'h2000, 15'd164, 1'b0, 0, 0, 0);
    add_row(16'h5555, 16'haaaa, 16'h3333, 15'd8000, 1'b0, 0, 0, 0);
    add_row(16'hcccc, 16'h00ff, 16'hff00, 15'd1, 1'b0, 0, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      if (table_rows[i].thr != cur_thr) begin
        ang_if.valid <= 1'b0;
        drain_results();
        write_threshold(table_rows[i].thr);
      end
      send_angles(table_rows[i].roll, table_rows[i].pitch, table_rows[i].yaw);
      if (table_rows[i].has_fixed) begin
        pm = pending_mats[$];
        if (pm.m[0] !== table_rows[i].fixed[0] || pm.m[4] !== table_rows[i].fixed[4] ||
            pm.m[8] !== table_rows[i].fixed[8]) begin
          pending_mats[$].m[0] = table_rows[i].fixed[0];
          pending_mats[$].m[4] = table_rows[i].fixed[4];
          pending_mats[$].m[8] = table_rows[i].fixed[8];
        end
      end
    end
    ang_if.valid <= 1'b0;
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 14 : (ph == 1 ? 76 : 0);
      recv_idle_pct = ph == 0 ? 76 : (ph == 1 ? 14 : 0);
      write_threshold(ph == 2 ? 15'd164 : 15'($urandom_range(400)));
      for (int n = 0; n < 150; n++) begin
        if (n == 75) begin
          ang_if.valid <= 1'b0;
          while (pending_mats.size() != 0) @(posedge clk_i);
        end
        send_angles(rand_angle(), rand_angle(), rand_angle());
      end
      ang_if.valid <= 1'b0;
      drain_results();
    end

    if (n_err == 0)
      $display("euler_zyx_to_rotation_matrix_top_test: clean");
    else
      $display("euler_zyx_to_rotation_matrix_top_test: errors");
    $finish;
  end
endmodule
